// ----- src/participation_sqrt_impact_slippage_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the participation slippage block
// Shared property forms, clocked by clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PARTICIPATION_SQRT_IMPACT_SLIPPAGE_DEFINES_SVH
`define PARTICIPATION_SQRT_IMPACT_SLIPPAGE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PSIS_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PSIS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/psis_pkg.sv -----
// ---------------------------------------------------------------------------
// psis_pkg
// Types and fixed constants of the participation slippage block.
// ---------------------------------------------------------------------------
`default_nettype none

package psis_pkg;

   localparam int QTY_W   = 32;
   localparam int URG_W   = 11;
   localparam int COEFF_W = 16;
   localparam int SLIP_W  = 20;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int M_W  = 15;
   localparam int AM_W = 31;
   localparam int K_W  = 43;

   localparam int unsigned MULT_BASE   = 8192;
   localparam int unsigned MULT_STEP   = 7;
   localparam int unsigned SCALE_NUM   = 3125;
   localparam int unsigned SCALE_SHIFT = 17;

   localparam logic [1:0] REG_COEFF = 2'd0;
   localparam logic [1:0] REG_MIN   = 2'd1;
   localparam logic [1:0] REG_MAX   = 2'd2;

   localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd2048;
   localparam logic [SLIP_W-1:0]  MIN_RESET   = 20'd0;
   localparam logic [SLIP_W-1:0]  MAX_RESET   = 20'd1000000;

   typedef struct packed {
      logic zero_vol;
      logic zero_diff;
      logic huge;
   } psis_flags_type;

   localparam int FLAGS_W = 3;

endpackage

`default_nettype wire

// ----- src/psis_div.sv -----
// ---------------------------------------------------------------------------
// psis_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none
`include "participation_sqrt_impact_slippage_defines.svh"

module psis_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              stg_vld  [NUM_W+1];
   logic [NUM_W-1:0]  stg_nq   [NUM_W+1];
   logic [SIDE_W-1:0] stg_side [NUM_W+1];
   logic [DEN_W-1:0]  stg_rem  [NUM_W];
   logic [DEN_W-1:0]  stg_den  [NUM_W];

   assign stg_vld[0]  = in_valid;
   assign stg_nq[0]   = in_num;
   assign stg_side[0] = in_side;
   assign stg_rem[0]  = '0;
   assign stg_den[0]  = in_den;

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic             vld_ff;
      logic [NUM_W-1:0] nq_ff;
      logic [SIDE_W-1:0] side_ff;

      assign trial = {stg_rem[g], stg_nq[g][NUM_W-1]};
      assign ge    = trial >= {1'b0, stg_den[g]};
      assign diff  = trial - {1'b0, stg_den[g]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= stg_vld[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff   <= {stg_nq[g][NUM_W-2:0], ge};
            side_ff <= stg_side[g];
         end
      end

      assign stg_vld[g+1]  = vld_ff;
      assign stg_nq[g+1]   = nq_ff;
      assign stg_side[g+1] = side_ff;

      if (g < NUM_W-1) begin : g_carry
         logic [DEN_W-1:0] rem_ff;
         logic [DEN_W-1:0] den_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               den_ff <= stg_den[g];
            end
         end
         assign stg_rem[g+1] = rem_ff;
         assign stg_den[g+1] = den_ff;
      end
   end

   assign out_valid = stg_vld[NUM_W];
   assign out_quo   = stg_nq[NUM_W];
   assign out_side  = stg_side[NUM_W];

   `PSIS_ASSERT_NEXT(a_div_hold, !adv && !reset, $stable(out_valid) && $stable(out_quo),
      "Divider output moved during a stall.")

endmodule

`default_nettype wire

// ----- src/psis_sqrt.sv -----
// ---------------------------------------------------------------------------
// psis_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module psis_sqrt #(
   parameter int IN_W   = 8,
   parameter int SIDE_W = 1,
   parameter int OUT_W  = (IN_W + 1) / 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [IN_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [OUT_W-1:0]       out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int PAD_W = 2 * OUT_W;
   localparam int REM_W = OUT_W + 2;
   localparam int SH_W  = OUT_W + 4;

   logic              stg_vld  [OUT_W+1];
   logic [OUT_W-1:0]  stg_res  [OUT_W+1];
   logic [SIDE_W-1:0] stg_side [OUT_W+1];
   logic [REM_W-1:0]  stg_rem  [OUT_W];
   logic [PAD_W-1:0]  stg_rad  [OUT_W];

   assign stg_vld[0]  = in_valid;
   assign stg_res[0]  = '0;
   assign stg_side[0] = in_side;
   assign stg_rem[0]  = '0;
   assign stg_rad[0]  = PAD_W'(in_rad);

   for (genvar g = 0; g < OUT_W; g++) begin : g_stage
      logic [SH_W-1:0]   sh;
      logic [SH_W-1:0]   trial;
      logic [SH_W-1:0]   diff;
      logic              ge;
      logic              vld_ff;
      logic [OUT_W-1:0]  res_ff;
      logic [SIDE_W-1:0] side_ff;

      assign sh    = {stg_rem[g], stg_rad[g][PAD_W-1:PAD_W-2]};
      assign trial = SH_W'({stg_res[g], 2'b01});
      assign ge    = sh >= trial;
      assign diff  = sh - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= stg_vld[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            res_ff  <= {stg_res[g][OUT_W-2:0], ge};
            side_ff <= stg_side[g];
         end
      end

      assign stg_vld[g+1]  = vld_ff;
      assign stg_res[g+1]  = res_ff;
      assign stg_side[g+1] = side_ff;

      if (g < OUT_W-1) begin : g_carry
         logic [REM_W-1:0] rem_ff;
         logic [PAD_W-1:0] rad_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
               rad_ff <= {stg_rad[g][PAD_W-3:0], 2'b00};
            end
         end
         assign stg_rem[g+1] = rem_ff;
         assign stg_rad[g+1] = rad_ff;
      end
   end

   assign out_valid = stg_vld[OUT_W];
   assign out_root  = stg_res[OUT_W];
   assign out_side  = stg_side[OUT_W];

endmodule

`default_nettype wire

// ----- src/psis_mul.sv -----
// ---------------------------------------------------------------------------
// psis_mul
// Pipelined multiplier that adds one 16-bit slice of the second operand
// per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module psis_mul #(
   parameter int A_W    = 16,
   parameter int B_W    = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [A_W-1:0]    in_a,
   input  wire logic [B_W-1:0]    in_b,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [A_W+B_W-1:0]     out_prod,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int CW   = 16;
   localparam int NC   = (B_W + CW - 1) / CW;
   localparam int BP_W = NC * CW;
   localparam int AC_W = A_W + BP_W;

   logic              stg_vld  [NC+1];
   logic [AC_W-1:0]   stg_acc  [NC+1];
   logic [SIDE_W-1:0] stg_side [NC+1];
   logic [A_W-1:0]    stg_a    [NC];
   logic [BP_W-1:0]   stg_b    [NC];

   assign stg_vld[0]  = in_valid;
   assign stg_acc[0]  = '0;
   assign stg_side[0] = in_side;
   assign stg_a[0]    = in_a;
   assign stg_b[0]    = BP_W'(in_b);

   for (genvar g = 0; g < NC; g++) begin : g_stage
      logic [CW-1:0]     slice;
      logic [A_W+CW-1:0] pp;
      logic              vld_ff;
      logic [AC_W-1:0]   acc_ff;
      logic [SIDE_W-1:0] side_ff;

      assign slice = stg_b[g][g*CW +: CW];
      assign pp    = stg_a[g] * slice;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= stg_vld[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff  <= stg_acc[g] + (AC_W'(pp) << (g * CW));
            side_ff <= stg_side[g];
         end
      end

      assign stg_vld[g+1]  = vld_ff;
      assign stg_acc[g+1]  = acc_ff;
      assign stg_side[g+1] = side_ff;

      if (g < NC-1) begin : g_carry
         logic [A_W-1:0]  a_ff;
         logic [BP_W-1:0] b_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               a_ff <= stg_a[g];
               b_ff <= stg_b[g];
            end
         end
         assign stg_a[g+1] = a_ff;
         assign stg_b[g+1] = b_ff;
      end
   end

   assign out_valid = stg_vld[NC];
   assign out_prod  = stg_acc[NC][A_W+B_W-1:0];
   assign out_side  = stg_side[NC];

endmodule

`default_nettype wire

// ----- src/participation_sqrt_impact_slippage.sv -----
// ---------------------------------------------------------------------------
// participation_sqrt_impact_slippage
// Square-root market impact estimate: slippage in hundredths of a basis
// point from order size, bar volume, bar range and urgency, clamped.
//
//   Port group   Direction   Handshake        Contents
//   req_*        in          valid / stall    one order and its price bar
//   rsp_*        out         valid / stall    slippage and zero-volume flag
//   APB          in/out      psel / penable   coefficient and clamp bounds
//
// One item enters per cycle while the output is not stalled. The pipeline has
// 2*FRAC_BITS + 32 divider stages, (2*FRAC_BITS + 33)/2 root stages, 64
// stages of the final divider, and front, scale, multiplier, shift and output stages.
// Reset is synchronous and clears the valid bits and the configuration registers.
// A stalled output freezes the whole pipeline and stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none
`include "participation_sqrt_impact_slippage_defines.svh"

module participation_sqrt_impact_slippage
   import psis_pkg::*;
#(
   parameter int VOLUME_BITS = 40,
   parameter int PRICE_BITS  = 32,
   parameter int FRAC_BITS   = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [QTY_W-1:0]       req_order_qty,
   input  wire logic [VOLUME_BITS-1:0] req_bar_volume,
   input  wire logic [PRICE_BITS-1:0]  req_price_high,
   input  wire logic [PRICE_BITS-1:0]  req_price_low,
   input  wire logic [PRICE_BITS-1:0]  req_price_close,
   input  wire logic [PRICE_BITS-1:0]  req_price_prev_close,
   input  wire logic [URG_W-1:0]       req_urgency_q10,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [SLIP_W-1:0]           rsp_slip_centibps,
   output logic                        rsp_zero_volume,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [ADDR_W-1:0]      paddr,
   input  wire logic [DATA_W-1:0]      pwdata,
   output logic [DATA_W-1:0]           prdata,
   output logic                        pready
);

   localparam int QN_W = QTY_W + 2 * FRAC_BITS;
   localparam int SW   = (QN_W + 1) / 2;
   localparam int KD_W = K_W + PRICE_BITS;
   localparam int PW   = KD_W + SW;
   localparam int SH   = SCALE_SHIFT + FRAC_BITS;
   localparam int S1_W = M_W + 2 * PRICE_BITS + FLAGS_W;
   localparam int S2_W = SW + PRICE_BITS + FLAGS_W;
   localparam int S3_W = PRICE_BITS + FLAGS_W;

   logic [COEFF_W-1:0] coeff_ff;
   logic [SLIP_W-1:0]  min_ff;
   logic [SLIP_W-1:0]  max_ff;
   logic               adv;

   assign pready    = 1'b1;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_RESET;
         min_ff   <= MIN_RESET;
         max_ff   <= MAX_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_COEFF: coeff_ff <= pwdata[COEFF_W-1:0];
            REG_MIN:   min_ff   <= pwdata[SLIP_W-1:0];
            REG_MAX:   max_ff   <= pwdata[SLIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_COEFF: prdata = DATA_W'(coeff_ff);
         REG_MIN:   prdata = DATA_W'(min_ff);
         REG_MAX:   prdata = DATA_W'(max_ff);
         default:   prdata = '0;
      endcase
   end

   // Front stage: reference price, bar range and urgency multiplier.
   logic [PRICE_BITS-1:0] ref_in;
   logic [PRICE_BITS-1:0] diff_in;
   logic                  diff_ok;
   psis_flags_type        flags_in;

   logic                  f_vld_ff;
   logic [QTY_W-1:0]      f_q_ff;
   logic [VOLUME_BITS-1:0] f_vol_ff;
   logic [PRICE_BITS-1:0] f_ref_ff;
   logic [PRICE_BITS-1:0] f_diff_ff;
   logic [M_W-1:0]        f_m_ff;
   psis_flags_type        f_flags_ff;

   assign ref_in  = (req_price_prev_close != '0) ? req_price_prev_close : req_price_close;
   assign diff_ok = (ref_in != '0) && (req_price_high != '0) &&
                    (req_price_low <= req_price_high);
   assign diff_in = diff_ok ? (req_price_high - req_price_low) : '0;

   always_comb begin
      flags_in.zero_vol  = (req_bar_volume == '0);
      flags_in.zero_diff = !diff_ok || (diff_in == '0);
      flags_in.huge      = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_q_ff     <= req_order_qty;
         f_vol_ff   <= req_bar_volume;
         f_ref_ff   <= ref_in;
         f_diff_ff  <= diff_in;
         f_m_ff     <= M_W'(MULT_BASE) + M_W'(req_urgency_q10) * M_W'(MULT_STEP);
         f_flags_ff <= flags_in;
      end
   end

   // Participation ratio q * 2^(2F) / V.
   logic                  d1_vld;
   logic [QN_W-1:0]       d1_quo;
   logic [S1_W-1:0]       d1_side;

   psis_div #(.NUM_W(QN_W), .DEN_W(VOLUME_BITS), .SIDE_W(S1_W)) u_ratio_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (f_vld_ff),
      .in_num   ({f_q_ff, {(2 * FRAC_BITS){1'b0}}}),
      .in_den   (f_vol_ff),
      .in_side  ({f_m_ff, f_diff_ff, f_ref_ff, f_flags_ff}),
      .out_valid(d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   logic                  sq_vld;
   logic [SW-1:0]         sq_root;
   logic [S1_W-1:0]       sq_side;
   logic [M_W-1:0]        sq_m;
   logic [PRICE_BITS-1:0] sq_diff;
   logic [PRICE_BITS-1:0] sq_ref;
   psis_flags_type        sq_flags;

   psis_sqrt #(.IN_W(QN_W), .SIDE_W(S1_W)) u_root (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (d1_vld),
      .in_rad   (d1_quo),
      .in_side  (d1_side),
      .out_valid(sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   assign {sq_m, sq_diff, sq_ref, sq_flags} = sq_side;

   // Scale factor A * (8192 + 7u) * 3125 over two stages.
   logic                  k1_vld_ff;
   logic [AM_W-1:0]       k1_am_ff;
   logic [SW-1:0]         k1_s_ff;
   logic [PRICE_BITS-1:0] k1_diff_ff;
   logic [PRICE_BITS-1:0] k1_ref_ff;
   psis_flags_type        k1_flags_ff;

   logic                  k2_vld_ff;
   logic [K_W-1:0]        k2_k_ff;
   logic [SW-1:0]         k2_s_ff;
   logic [PRICE_BITS-1:0] k2_diff_ff;
   logic [PRICE_BITS-1:0] k2_ref_ff;
   psis_flags_type        k2_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_vld_ff <= 1'b0;
         k2_vld_ff <= 1'b0;
      end else if (adv) begin
         k1_vld_ff <= sq_vld;
         k2_vld_ff <= k1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_am_ff    <= AM_W'(coeff_ff) * AM_W'(sq_m);
         k1_s_ff     <= sq_root;
         k1_diff_ff  <= sq_diff;
         k1_ref_ff   <= sq_ref;
         k1_flags_ff <= sq_flags;
         k2_k_ff     <= K_W'(k1_am_ff) * K_W'(SCALE_NUM);
         k2_s_ff     <= k1_s_ff;
         k2_diff_ff  <= k1_diff_ff;
         k2_ref_ff   <= k1_ref_ff;
         k2_flags_ff <= k1_flags_ff;
      end
   end

   logic                  m1_vld;
   logic [KD_W-1:0]       m1_prod;
   logic [S2_W-1:0]       m1_side;
   logic [SW-1:0]         m1_s;
   logic [PRICE_BITS-1:0] m1_ref;
   psis_flags_type        m1_flags;

   psis_mul #(.A_W(K_W), .B_W(PRICE_BITS), .SIDE_W(S2_W)) u_range_mul (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (k2_vld_ff),
      .in_a     (k2_k_ff),
      .in_b     (k2_diff_ff),
      .in_side  ({k2_s_ff, k2_ref_ff, k2_flags_ff}),
      .out_valid(m1_vld),
      .out_prod (m1_prod),
      .out_side (m1_side)
   );

   assign {m1_s, m1_ref, m1_flags} = m1_side;

   logic                  m2_vld;
   logic [PW-1:0]         m2_prod;
   logic [S3_W-1:0]       m2_side;
   logic [PRICE_BITS-1:0] m2_ref;
   psis_flags_type        m2_flags;

   psis_mul #(.A_W(KD_W), .B_W(SW), .SIDE_W(S3_W)) u_root_mul (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (m1_vld),
      .in_a     (m1_prod),
      .in_b     (m1_s),
      .in_side  ({m1_ref, m1_flags}),
      .out_valid(m2_vld),
      .out_prod (m2_prod),
      .out_side (m2_side)
   );

   assign {m2_ref, m2_flags} = m2_side;

   // Drop the fraction; anything at or above 2^64 saturates to the maximum.
   logic [PW+63:0]        sh_ext;
   psis_flags_type        sh_flags_in;
   logic                  y_vld_ff;
   logic [63:0]           y_ff;
   logic [PRICE_BITS-1:0] y_ref_ff;
   psis_flags_type        y_flags_ff;

   assign sh_ext = {64'b0, m2_prod} >> SH;

   always_comb begin
      sh_flags_in      = m2_flags;
      sh_flags_in.huge = |sh_ext[PW+63:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_vld_ff <= 1'b0;
      end else if (adv) begin
         y_vld_ff <= m2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff       <= sh_ext[63:0];
         y_ref_ff   <= m2_ref;
         y_flags_ff <= sh_flags_in;
      end
   end

   logic                  d2_vld;
   logic [63:0]           d2_quo;
   psis_flags_type        d2_flags;

   psis_div #(.NUM_W(64), .DEN_W(PRICE_BITS), .SIDE_W(FLAGS_W)) u_price_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (y_vld_ff),
      .in_num   (y_ff),
      .in_den   (y_ref_ff),
      .in_side  (y_flags_ff),
      .out_valid(d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_flags)
   );

   // Clamp and output register.
   logic [63:0]       x_in;
   logic [SLIP_W-1:0] upper_in;
   logic [SLIP_W-1:0] slip_in;
   logic              rsp_valid_ff;
   logic [SLIP_W-1:0] rsp_slip_ff;
   logic              rsp_zero_ff;

   always_comb begin
      x_in     = d2_flags.zero_diff ? 64'd0 : d2_quo;
      upper_in = (d2_flags.huge || (x_in > 64'(max_ff))) ? max_ff : x_in[SLIP_W-1:0];
      slip_in  = (d2_flags.zero_vol || (upper_in < min_ff)) ? min_ff : upper_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_slip_ff <= slip_in;
         rsp_zero_ff <= d2_flags.zero_vol;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slip_centibps = rsp_slip_ff;
   assign rsp_zero_volume   = rsp_zero_ff;

   `PSIS_ASSERT_NOW(a_zero_vol_min, rsp_valid && rsp_zero_volume,
      rsp_slip_centibps == min_ff, "Zero-volume item did not return the minimum.")
   `PSIS_ASSERT_NOW(a_floor, rsp_valid, rsp_slip_centibps >= min_ff,
      "Result fell below the lower clamp.")
   `PSIS_ASSERT_NOW(a_back_pressure, rsp_valid && rsp_stall, req_stall,
      "Input accepted while the output item was stalled.")

endmodule

`default_nettype wire
